### design/led_breathing_envelope_macros.svh
// ----------------------------------------------------------------------------
// LED breathing envelope assertion macros
// Shared property forms for the checkers of the breathing envelope.
// ----------------------------------------------------------------------------
`ifndef LED_BREATHING_ENVELOPE_MACROS_SVH
`define LED_BREATHING_ENVELOPE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lbe_pkg.sv
// ----------------------------------------------------------------------------
// LED breathing envelope package
// Widths, constants, codes and the divider request/response types.
// ----------------------------------------------------------------------------
package lbe_pkg;

  // Field and register widths.
  localparam int MODE_W  = 2;
  localparam int TOP_W   = 16;
  localparam int DUTY_W  = 8;

  // Iterative divider sizing: the widest dividend is 1000 times a 16-bit offset.
  localparam int DIV_W   = 26;
  localparam int ITER_W  = $clog2(DIV_W + 1);

  // Envelope arithmetic constants.
  localparam int PWM_TOP        = 255;
  localparam int PERMILLE_SCALE = 1000;
  localparam int PERCENT_SCALE  = 100;
  localparam int FIFTH_DIVISOR  = 5;

  // Animation mode codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_OFF   = 2'd0,
    MODE_RED   = 2'd1,
    MODE_GREEN = 2'd2,
    MODE_BLUE  = 2'd3
  } anim_mode_t;

  // Register indexes as decoded from the word address.
  typedef enum logic {
    REG_ANIM_MODE  = 1'b0,
    REG_PERIOD_TOP = 1'b1
  } reg_idx_t;

  // Request to the shared divider. The dividend is left-aligned in DIV_W bits
  // and iters gives the number of significant dividend bits.
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [TOP_W-1:0]  divisor;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  // Response of the shared divider: done pulses for one cycle.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### design/lbe_div.sv
// ----------------------------------------------------------------------------
// LED breathing envelope divider
// Restoring divider that retires one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module lbe_div
  import lbe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r,  busy_nxt;
  logic              done_r,  done_nxt;
  logic [ITER_W-1:0] cnt_r,   cnt_nxt;
  logic [DIV_W-1:0]  num_r,   num_nxt;
  logic [DIV_W-1:0]  quo_r,   quo_nxt;
  logic [TOP_W-1:0]  rem_r,   rem_nxt;
  logic [TOP_W-1:0]  dvs_r,   dvs_nxt;
  logic [TOP_W:0]    trial;

  // One shift-subtract step per cycle while busy.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, num_r[DIV_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.iters;
      num_nxt  = req.dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = TOP_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[TOP_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - ITER_W'(1);
      if (cnt_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Datapath registers hold; control registers clear on reset.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### design/led_breathing_envelope.sv
// ----------------------------------------------------------------------------
// LED breathing envelope
// Breathing-light duty generator for one channel of an RGB LED.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one tick flag in in_tdata[0]. A tick
// of 0 is accepted while idle and gives no result. A tick of 1 gives exactly
// one output transaction with the red, green and blue duties and led_power.
// Registers anim_mode (address 0) and period_top (address 4) are written over
// the APB port; the user must write them only while the block is idle, as the
// block itself does not enforce it. Either write clears the progress count.
// With animation on, a nonzero period_top and the count inside the first
// fifth of the period, one tick runs the shared restoring divider three times
// (a 16-bit, a 26-bit and a 15-bit division) under the sequencer before
// out_tvalid rises. Past the first fifth only the first division runs. With
// mode 0 or a zero top no division is done.
// in_tready is low from the acceptance of a tick until its result is loaded
// into the output register, so the block takes no new tick before then.
// If the receiver stalls, the result waits in the output register; the block
// still accepts the next tick and holds the following result in its sequencer
// until the output register frees up.
// Reset (rst_n low at a clock edge) returns mode 0, period_top 1000 and a
// progress count of 0, and drops out_tvalid.
// ----------------------------------------------------------------------------
module led_breathing_envelope
  import lbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: [0] tick, [7:1] unused
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // Output stream: [7:0] red_duty, [15:8] green_duty, [23:16] blue_duty,
  // [24] led_power, [31:25] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIFTH,
    S_CHECK,
    S_PERMILLE,
    S_LEVEL,
    S_FINISH
  } state_t;

  state_t              state_r,  state_nxt;
  anim_mode_t          mode_r,   mode_nxt;
  logic [TOP_W-1:0]    top_r,    top_nxt;
  logic [TOP_W-1:0]    count_r,  count_nxt;
  logic [TOP_W-1:0]    off_r,    off_nxt;
  logic                down_r,   down_nxt;
  logic [DUTY_W-1:0]   level_r,  level_nxt;
  logic                oval_r,   oval_nxt;
  logic [DUTY_W-1:0]   red_r,    red_nxt;
  logic [DUTY_W-1:0]   green_r,  green_nxt;
  logic [DUTY_W-1:0]   blue_r,   blue_nxt;
  logic                power_r,  power_nxt;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic [TOP_W-1:0]    fifth;
  logic [TOP_W-1:0]    tenth;
  logic [TOP_W:0]      count_inc;
  logic [DUTY_W-1:0]   ramp;
  logic [14:0]         scaled;

  // Shared iterative divider.
  lbe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  // Quotient taps for each phase of the sequence.
  assign fifth     = div_rsp.quotient[TOP_W-1:0];
  assign tenth     = {1'b0, fifth[TOP_W-1:1]};
  assign ramp      = div_rsp.quotient[DUTY_W-1:0];
  assign scaled    = {8'd0, div_rsp.quotient[6:0]} * 15'(PWM_TOP);
  assign count_inc = {1'b0, count_r} + (TOP_W+1)'(1);

  // Sequencer, output register and configuration writes.
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    top_nxt   = top_r;
    count_nxt = count_r;
    off_nxt   = off_r;
    down_nxt  = down_r;
    level_nxt = level_r;
    oval_nxt  = oval_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    power_nxt = power_r;
    div_req   = '0;

    if (oval_r && out_tready) begin
      oval_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tdata[0]) begin
          if (mode_r == MODE_OFF || top_r == '0) begin
            level_nxt = '0;
            state_nxt = S_FINISH;
          end else begin
            // The fifth of the period; the tenth is half of it.
            div_req.start    = 1'b1;
            div_req.dividend = {top_r, (DIV_W-TOP_W)'(0)};
            div_req.divisor  = TOP_W'(FIFTH_DIVISOR);
            div_req.iters    = ITER_W'(TOP_W);
            state_nxt        = S_FIFTH;
          end
        end
      end
      S_FIFTH: begin
        if (div_rsp.done) begin
          if (count_r < tenth) begin
            off_nxt   = count_r;
            down_nxt  = 1'b0;
            state_nxt = S_CHECK;
          end else if (count_r < fifth) begin
            off_nxt   = count_r - tenth;
            down_nxt  = 1'b1;
            state_nxt = S_CHECK;
          end else begin
            level_nxt = '0;
            state_nxt = S_FINISH;
          end
        end
      end
      S_CHECK: begin
        // Per-mille position within the ramp.
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'({10'd0, off_r} * DIV_W'(PERMILLE_SCALE));
        div_req.divisor  = top_r;
        div_req.iters    = ITER_W'(DIV_W);
        state_nxt        = S_PERMILLE;
      end
      S_PERMILLE: begin
        // Per-mille stays below 100 here, so seven bits carry it.
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {scaled, (DIV_W-15)'(0)};
          div_req.divisor  = TOP_W'(PERCENT_SCALE);
          div_req.iters    = ITER_W'(15);
          state_nxt        = S_LEVEL;
        end
      end
      S_LEVEL: begin
        // The ramp never exceeds 252, so the falling edge needs no clamp.
        if (div_rsp.done) begin
          level_nxt = down_r ? DUTY_W'(PWM_TOP) - ramp : ramp;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!oval_r || out_tready) begin
          oval_nxt  = 1'b1;
          red_nxt   = (mode_r == MODE_RED)   ? level_r : '0;
          green_nxt = (mode_r == MODE_GREEN) ? level_r : '0;
          blue_nxt  = (mode_r == MODE_BLUE)  ? level_r : '0;
          power_nxt = (mode_r != MODE_OFF) && (level_r != '0);
          if (mode_r != MODE_OFF) begin
            count_nxt = (count_inc > {1'b0, top_r}) ? '0 : count_inc[TOP_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Either register write restarts the animation period.
    if (cfg_wr) begin
      case (cfg_idx)
        REG_ANIM_MODE:  mode_nxt = anim_mode_t'(pwdata[MODE_W-1:0]);
        REG_PERIOD_TOP: top_nxt  = pwdata[TOP_W-1:0];
        default:        mode_nxt = mode_r;
      endcase
      count_nxt = '0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    off_r   <= off_nxt;
    down_r  <= down_nxt;
    level_r <= level_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    power_r <= power_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_OFF;
      top_r   <= TOP_W'(PERMILLE_SCALE);
      count_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      top_r   <= top_nxt;
      count_r <= count_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;
  assign out_tdata  = {7'd0, power_r, blue_r, green_r, red_r};

  // Register read-back.
  assign prdata = (cfg_idx == REG_PERIOD_TOP) ? {16'd0, top_r} : {30'd0, mode_r};
  assign pready = 1'b1;

endmodule

### design/lbe_checker.sv
// ----------------------------------------------------------------------------
// LED breathing envelope checker
// Port-level assertions on the result stream and the tick sequencing.
// ----------------------------------------------------------------------------
`include "led_breathing_envelope_macros.svh"

module lbe_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // led_power must reflect exactly whether any duty is lit.
  `LBE_ASSERT_NOW(a_power_match, out_tvalid,
                  out_tdata[24] == (out_tdata[23:0] != 24'd0),
                  "led_power does not match the duties")

  // Only the selected channel may carry brightness.
  `LBE_ASSERT_NOW(a_one_channel, out_tvalid,
                  $countones({out_tdata[7:0] != 8'd0, out_tdata[15:8] != 8'd0,
                              out_tdata[23:16] != 8'd0}) <= 1,
                  "more than one channel lit")

  // A tick keeps the block busy in the following cycle.
  `LBE_ASSERT_NEXT(a_tick_busy, in_tvalid && in_tready && in_tdata[0], !in_tready,
                   "block ready right after a tick")

  // A stalled result holds its value.
  `LBE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind led_breathing_envelope lbe_assertions u_lbe_assertions (.*);
